### rtl/sils_pkg.sv
// Shared types and constants of the sorted id list seek block.
package sils_pkg;

   localparam int ID_W  = 32;
   localparam int IDX_W = 12;
   localparam int POS_W = 13;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 1;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_SEEK = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_LIST_LENGTH = 1'b0;

   typedef struct packed {
      logic             req_type;
      logic [IDX_W-1:0] entry_index;
      logic [ID_W-1:0]  value;
   } req_payload_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             found;
   } rsp_payload_type;

   typedef struct packed {
      logic             hit;
      logic             last;
      logic [POS_W-1:0] position;
   } lane_result_type;

endpackage

### rtl/sorted_id_list_seek.sv
// A load request writes one id into the store and returns nothing. A seek request reads the
// store one row per cycle, starting at the row that holds its start position, and compares
// all ids of a row at once; a row holds COMPARE_LANES ids, rounded up to a power of two. A
// seek holds off new requests, since the store has a single read port, until its last row
// has been compared and its result has a free output slot. The result sits in an output
// register, so new requests are taken while it waits to be delivered.
module sorted_id_list_seek #(
   parameter int MAX_IDS       = 4096,
   parameter int COMPARE_LANES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sils_pkg::req_payload_type          req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sils_pkg::rsp_payload_type          rsp_payload,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sils_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sils_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sils_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int LANE_BITS = (COMPARE_LANES > 1) ? $clog2(COMPARE_LANES) : 0;
   localparam int BANKS     = 1 << LANE_BITS;
   localparam int ROWS      = (MAX_IDS + BANKS - 1) / BANKS;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int BANK_W    = (BANKS > 1) ? $clog2(BANKS) : 1;
   localparam int POS_W     = sils_pkg::POS_W;
   localparam int PW        = POS_W + 1;
   localparam int MAX_LEN   = (MAX_IDS > 8191) ? 8191 : MAX_IDS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type                  state_ff, state_in;
   logic [POS_W-1:0]           list_length_ff, list_length_in;
   logic [PW-1:0]              base_ff, base_in;
   logic [POS_W-1:0]           start_ff, start_in;
   logic [sils_pkg::ID_W-1:0]  target_ff, target_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   sils_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic                       req_accept;
   logic                       csr_write;
   logic [POS_W-1:0]           eff_len;
   logic                       wr_en;
   logic [ROW_W-1:0]           wr_row;
   logic [BANK_W-1:0]          wr_lane;
   logic                       rd_en;
   logic [ROW_W-1:0]           rd_row;
   logic [BANKS*sils_pkg::ID_W-1:0] rd_data;
   logic [31:0]                idx_row_wide;
   logic [31:0]                idx_lane_wide;
   logic [PW-1:0]              base_next;
   logic [31:0]                next_row_wide;
   logic [PW-1:0]              start_aligned;
   sils_pkg::lane_result_type  lane_res;
   logic                       scan_done;
   logic                       slot_free;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == sils_pkg::CSR_LIST_LENGTH);

   assign csr_prdata = (csr_paddr == sils_pkg::CSR_LIST_LENGTH)
                       ? {{(sils_pkg::CSR_DATA_W - POS_W){1'b0}}, list_length_ff} : '0;

   assign eff_len = (list_length_ff > POS_W'(MAX_LEN)) ? POS_W'(MAX_LEN) : list_length_ff;

   assign idx_row_wide  = 32'(req_payload.entry_index) >> LANE_BITS;
   assign idx_lane_wide = 32'(req_payload.entry_index) & 32'(BANKS - 1);
   assign start_aligned = PW'(req_payload.entry_index) & ~PW'(BANKS - 1);
   assign base_next     = base_ff + PW'(BANKS);
   assign next_row_wide = 32'(base_next) >> LANE_BITS;

   assign wr_en   = req_accept && (req_payload.req_type == sils_pkg::REQ_LOAD)
                    && (32'(req_payload.entry_index) < 32'(MAX_IDS));
   assign wr_row  = idx_row_wide[ROW_W-1:0];
   assign wr_lane = idx_lane_wide[BANK_W-1:0];

   assign scan_done = lane_res.hit || lane_res.last;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      base_in        = base_ff;
      start_in       = start_ff;
      target_in      = target_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      list_length_in = csr_write ? csr_pwdata[POS_W-1:0] : list_length_ff;
      rd_en          = 1'b0;
      rd_row         = next_row_wide[ROW_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            rd_row = idx_row_wide[ROW_W-1:0];
            if (req_accept && (req_payload.req_type == sils_pkg::REQ_SEEK)) begin
               rd_en     = 1'b1;
               base_in   = start_aligned;
               start_in  = POS_W'(req_payload.entry_index);
               target_in = req_payload.value;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (slot_free) begin
                  rsp_valid_in            = 1'b1;
                  rsp_payload_in.found    = lane_res.hit;
                  rsp_payload_in.position = lane_res.hit ? lane_res.position : eff_len;
                  state_in                = ST_IDLE;
               end
            end else begin
               rd_en   = 1'b1;
               base_in = base_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         list_length_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         list_length_ff <= list_length_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff        <= base_in;
      start_ff       <= start_in;
      target_ff      <= target_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   sils_store #(
      .ROWS  (ROWS),
      .LANES (BANKS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_row  (wr_row),
      .wr_lane (wr_lane),
      .wr_data (req_payload.value),
      .rd_en   (rd_en),
      .rd_row  (rd_row),
      .rd_data (rd_data)
   );

   sils_lanes #(
      .LANES (BANKS)
   ) u_lanes (
      .row_data (rd_data),
      .base     (base_ff),
      .start    (start_ff),
      .length   (eff_len),
      .target   (target_ff),
      .result   (lane_res)
   );

endmodule

### rtl/sils_store.sv
// Id store: one row of ids per address, one id written per load, one row read per cycle while rd_en is high.
module sils_store #(
   parameter int ROWS  = 512,
   parameter int LANES = 8
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0]   wr_row,
   input  logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] wr_lane,
   input  logic [sils_pkg::ID_W-1:0]     wr_data,
   input  logic                          rd_en,
   input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0]   rd_row,
   output logic [LANES*sils_pkg::ID_W-1:0] rd_data
);

   localparam int BANK_W = (LANES > 1) ? $clog2(LANES) : 1;

   logic [LANES*sils_pkg::ID_W-1:0] mem [ROWS];
   logic [LANES*sils_pkg::ID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int l = 0; l < LANES; l++) begin
            if (wr_lane == BANK_W'(l)) begin
               mem[wr_row][l*sils_pkg::ID_W +: sils_pkg::ID_W] <= wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sils_lanes.sv
// Compare lanes: tests one row of ids against the target and picks the first qualifying one.
module sils_lanes #(
   parameter int LANES = 8
) (
   input  logic [LANES*sils_pkg::ID_W-1:0] row_data,
   input  logic [sils_pkg::POS_W:0]        base,
   input  logic [sils_pkg::POS_W-1:0]      start,
   input  logic [sils_pkg::POS_W-1:0]      length,
   input  logic [sils_pkg::ID_W-1:0]       target,
   output sils_pkg::lane_result_type       result
);

   localparam int PW = sils_pkg::POS_W + 1;

   always_comb begin
      logic [PW-1:0] lane_pos;
      result.hit      = 1'b0;
      result.position = '0;
      result.last     = ((base + PW'(LANES)) >= {1'b0, length});
      for (int l = LANES - 1; l >= 0; l--) begin
         lane_pos = base + PW'(l);
         if ((lane_pos >= {1'b0, start}) && (lane_pos < {1'b0, length})
               && (row_data[l*sils_pkg::ID_W +: sils_pkg::ID_W] >= target)) begin
            result.hit      = 1'b1;
            result.position = lane_pos[sils_pkg::POS_W-1:0];
         end
      end
   end

endmodule

### rtl/sils_checker.sv
// Port-level checks of the sorted id list seek block and their binding to it.
module sils_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input sils_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input sils_pkg::rsp_payload_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed or dropped");

   a_seek_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.req_type == sils_pkg::REQ_SEEK) |=> req_stall)
      else $error("seek request did not occupy the block");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.req_type == sils_pkg::REQ_LOAD) && !rsp_valid
      |=> !rsp_valid)
      else $error("load request produced a response");

   a_rsp_from_seek: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a seek in progress");

endmodule

bind sorted_id_list_seek sils_checker u_checker (.*);
